### rtl/hht_pkg.sv
// Shared types, constants and helpers for the hopscotch hash table engine.
package hht_pkg;

	localparam int TABLE_LOG2_DEF = 10;
	localparam int HOP_RANGE_DEF  = 32;
	localparam int KEY_BYTES_DEF  = 8;
	localparam int VALUE_BITS_DEF = 64;

	localparam int          SIZE_EXP_W     = 4;
	localparam logic [3:0]  SIZE_EXP_RESET = 4'd10;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_MISS = 3'd1,
		ST_DUP  = 3'd2,
		ST_FULL = 3'd3,
		ST_HOOD = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_HFIN,
		S_MAP_RD,
		S_MAP_CAP,
		S_FIND,
		S_FIND_CMP,
		S_HIT,
		S_NOTFOUND,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_DISP,
		S_MOVE_RD,
		S_MOVE_CHK,
		S_MOVE_KRD,
		S_MOVE_WR,
		S_FINAL_WR,
		S_EMIT
	} state_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_CLEAR,
		DP_LOAD,
		DP_HASH,
		DP_HFIN,
		DP_MAP_RD,
		DP_MAP_CAP,
		DP_FIND_RD,
		DP_FIND_NEXT,
		DP_LK_HIT,
		DP_REMOVE,
		DP_SET_RES,
		DP_PROBE_INIT,
		DP_PROBE_RD,
		DP_PROBE_TAKE,
		DP_PROBE_NEXT,
		DP_MOVE_INIT,
		DP_MOVE_RD,
		DP_MOVE_CAP,
		DP_MOVE_KRD,
		DP_MOVE_WR,
		DP_MOVE_NEXT,
		DP_HOOD_REL,
		DP_FINAL_RD,
		DP_FINAL_WR,
		DP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t st;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic byte_last;
		op_t  op;
		logic bit_hit;
		logic i_last;
		logic key_match;
		logic taken;
		logic probe_last;
		logic in_hood;
		logic move_ok;
		logic j_last;
	} stat_t;

	function automatic logic [4:0] lowest_set(input logic [31:0] m);
		logic [4:0] r;
		r = 5'd31;
		for (int n = 31; n >= 0; n--) begin
			if (m[n]) begin
				r = 5'(n);
			end
		end
		return r;
	endfunction

endpackage

### rtl/hht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hht_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/hht_datapath.sv
// Datapath: hash unit, bucket memories, probe and displacement registers, result registers.
module hht_datapath #(
	parameter int TABLE_LOG2 = hht_pkg::TABLE_LOG2_DEF,
	parameter int HOP_RANGE  = hht_pkg::HOP_RANGE_DEF,
	parameter int KEY_BYTES  = hht_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BITS = hht_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hht_pkg::cmd_t         cmd,
	output hht_pkg::stat_t        stat,
	input  logic                  cfg_we,
	input  logic [3:0]            cfg_wdata,
	input  logic [1:0]            operation,
	input  logic [63:0]           key,
	input  logic [63:0]           value,
	output logic [2:0]            status,
	output logic [63:0]           value_out
);

	localparam int TL    = TABLE_LOG2;
	localparam int DEPTH = 1 << TL;
	localparam int IW    = $clog2(HOP_RANGE);
	localparam int KW    = 8 * KEY_BYTES;
	localparam int BCW   = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	logic [3:0]            size_exp_q;
	logic [TL-1:0]         clr_cnt_q;
	logic [1:0]            op_q;
	logic [KW-1:0]         key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [31:0]           hash_q;
	logic [BCW-1:0]        byte_cnt_q;
	logic [TL-1:0]         home_q;
	logic [HOP_RANGE-1:0]  map_q;
	logic [IW-1:0]         i_q;
	logic [IW-1:0]         j_q;
	logic [IW-1:0]         off_q;
	logic [TL-1:0]         free_q;
	logic [TL-1:0]         anchor_q;
	logic [TL-1:0]         from_q;
	logic [2:0]            res_status_q;
	logic [VALUE_BITS-1:0] res_value_q;
	logic [2:0]            out_status_q;
	logic [VALUE_BITS-1:0] out_value_q;

	logic [4:0]            e_eff;
	logic [TL-1:0]         mask;
	logic [7:0]            key_byte;
	logic [31:0]           h1, h2, h3, f1, f2, f3;
	logic [TL:0]           slot_ext;
	logic [TL-1:0]         slot;
	logic [TL-1:0]         diff;
	logic [TL-1:0]         anchor;
	logic [4:0]            off;

	logic                  k_we, k_re, m_we, m_re, t_we, t_re;
	logic [TL-1:0]         k_waddr, k_raddr, m_waddr, m_raddr, t_waddr, t_raddr;
	logic [HOP_RANGE-1:0]  m_wdata;
	logic                  t_wdata;
	logic [KW-1:0]         k_wdata, k_rdata;
	logic [VALUE_BITS-1:0] v_wdata, v_rdata;
	logic [HOP_RANGE-1:0]  m_rdata;
	logic                  t_rdata;

	always_comb begin
		if (size_exp_q == 4'd0) begin
			e_eff = 5'd1;
		end else if (5'(size_exp_q) > 5'(TL)) begin
			e_eff = 5'(TL);
		end else begin
			e_eff = 5'(size_exp_q);
		end
	end

	assign mask     = TL'((32'd1 << e_eff) - 32'd1);
	assign key_byte = 8'(key_q >> {byte_cnt_q, 3'b000});
	assign h1       = hash_q + 32'(key_byte);
	assign h2       = h1 + (h1 << 10);
	assign h3       = h2 ^ (h2 >> 6);
	assign f1       = hash_q + (hash_q << 3);
	assign f2       = f1 ^ (f1 >> 11);
	assign f3       = f2 + (f2 << 15);
	assign slot_ext = {1'b0, home_q} + (TL+1)'(i_q);
	assign slot     = slot_ext[TL-1:0];
	assign diff     = free_q - home_q;
	assign anchor   = free_q - TL'(j_q);
	assign off      = hht_pkg::lowest_set(32'(m_rdata));

	assign stat.clr_last   = (clr_cnt_q == TL'(DEPTH - 1));
	assign stat.byte_last  = (byte_cnt_q == BCW'(KEY_BYTES - 1));
	assign stat.op         = hht_pkg::op_t'(op_q);
	assign stat.bit_hit    = map_q[i_q] && !slot_ext[TL];
	assign stat.i_last     = (i_q == IW'(HOP_RANGE - 1));
	assign stat.key_match  = (k_rdata == key_q);
	assign stat.taken      = t_rdata;
	assign stat.probe_last = (free_q == mask);
	assign stat.in_hood    = (32'(diff) < 32'(HOP_RANGE));
	assign stat.move_ok    = (|m_rdata) && (6'(off) < 6'(j_q));
	assign stat.j_last     = (j_q == IW'(HOP_RANGE - 1));

	always_comb begin
		k_we = 1'b0; k_re = 1'b0; k_waddr = free_q; k_raddr = slot;
		k_wdata = key_q; v_wdata = val_q;
		m_we = 1'b0; m_re = 1'b0; m_waddr = home_q; m_raddr = home_q;
		m_wdata = '0;
		t_we = 1'b0; t_re = 1'b0; t_waddr = free_q; t_raddr = free_q;
		t_wdata = 1'b0;
		case (cmd.op)
			hht_pkg::DP_CLEAR: begin
				m_we = 1'b1; m_waddr = clr_cnt_q;
				t_we = 1'b1; t_waddr = clr_cnt_q;
			end
			hht_pkg::DP_MAP_RD, hht_pkg::DP_FINAL_RD: begin
				m_re = 1'b1;
			end
			hht_pkg::DP_FIND_RD: begin
				k_re = 1'b1;
			end
			hht_pkg::DP_REMOVE: begin
				m_we = 1'b1;
				m_wdata = map_q & ~(HOP_RANGE'(1) << i_q);
				t_we = 1'b1; t_waddr = slot;
			end
			hht_pkg::DP_PROBE_RD: begin
				t_re = 1'b1;
			end
			hht_pkg::DP_PROBE_TAKE: begin
				t_we = 1'b1; t_wdata = 1'b1;
			end
			hht_pkg::DP_MOVE_RD: begin
				m_re = 1'b1; m_raddr = anchor;
			end
			hht_pkg::DP_MOVE_KRD: begin
				k_re = 1'b1; k_raddr = from_q;
			end
			hht_pkg::DP_MOVE_WR: begin
				k_we = 1'b1; k_wdata = k_rdata; v_wdata = v_rdata;
				m_we = 1'b1; m_waddr = anchor_q;
				m_wdata = (map_q & ~(HOP_RANGE'(1) << off_q)) | (HOP_RANGE'(1) << j_q);
			end
			hht_pkg::DP_HOOD_REL: begin
				t_we = 1'b1;
			end
			hht_pkg::DP_FINAL_WR: begin
				k_we = 1'b1;
				m_we = 1'b1;
				m_wdata = m_rdata | (HOP_RANGE'(1) << IW'(diff));
			end
			default: begin
			end
		endcase
	end

	hht_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_keys (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
		.re(k_re), .raddr(k_raddr), .rdata(k_rdata)
	);

	hht_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_values (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(v_wdata),
		.re(k_re), .raddr(k_raddr), .rdata(v_rdata)
	);

	hht_ram #(.WIDTH(HOP_RANGE), .DEPTH(DEPTH)) u_maps (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.re(m_re), .raddr(m_raddr), .rdata(m_rdata)
	);

	hht_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_taken (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.re(t_re), .raddr(t_raddr), .rdata(t_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_exp_q <= hht_pkg::SIZE_EXP_RESET;
			clr_cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				size_exp_q <= cfg_wdata;
			end
			if (cmd.op == hht_pkg::DP_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + TL'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			hht_pkg::DP_LOAD: begin
				op_q       <= operation;
				key_q      <= key[KW-1:0];
				val_q      <= value[VALUE_BITS-1:0];
				hash_q     <= '0;
				byte_cnt_q <= '0;
			end
			hht_pkg::DP_HASH: begin
				hash_q     <= h3;
				byte_cnt_q <= byte_cnt_q + BCW'(1);
			end
			hht_pkg::DP_HFIN: begin
				home_q <= f3[TL-1:0] & mask;
			end
			hht_pkg::DP_MAP_RD: begin
				i_q <= '0;
			end
			hht_pkg::DP_MAP_CAP: begin
				map_q <= m_rdata;
			end
			hht_pkg::DP_FIND_NEXT: begin
				i_q <= i_q + IW'(1);
			end
			hht_pkg::DP_LK_HIT, hht_pkg::DP_REMOVE: begin
				res_status_q <= hht_pkg::ST_OK;
				res_value_q  <= v_rdata;
			end
			hht_pkg::DP_SET_RES, hht_pkg::DP_HOOD_REL: begin
				res_status_q <= cmd.st;
				res_value_q  <= '0;
			end
			hht_pkg::DP_PROBE_INIT: begin
				free_q <= home_q;
			end
			hht_pkg::DP_PROBE_NEXT: begin
				free_q <= free_q + TL'(1);
			end
			hht_pkg::DP_MOVE_INIT: begin
				j_q <= IW'(1);
			end
			hht_pkg::DP_MOVE_RD: begin
				anchor_q <= anchor;
			end
			hht_pkg::DP_MOVE_CAP: begin
				map_q  <= m_rdata;
				off_q  <= IW'(off);
				from_q <= anchor_q + TL'(off);
			end
			hht_pkg::DP_MOVE_WR: begin
				free_q <= from_q;
			end
			hht_pkg::DP_MOVE_NEXT: begin
				j_q <= j_q + IW'(1);
			end
			hht_pkg::DP_FINAL_WR: begin
				res_status_q <= hht_pkg::ST_OK;
				res_value_q  <= '0;
			end
			hht_pkg::DP_EMIT: begin
				out_status_q <= res_status_q;
				out_value_q  <= res_value_q;
			end
			default: begin
			end
		endcase
	end

	assign status    = out_status_q;
	assign value_out = 64'(out_value_q);

endmodule

### rtl/hht_ctrl.sv
// Controller state machine: sequences table clearing, hash, search, probe, displacement and result transfer.
module hht_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  hht_pkg::stat_t stat,
	output hht_pkg::cmd_t  cmd
);

	hht_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			hht_pkg::S_CLEAR:    if (stat.clr_last) state_d = hht_pkg::S_IDLE;
			hht_pkg::S_IDLE:     if (in_valid) state_d = hht_pkg::S_HASH;
			hht_pkg::S_HASH:     if (stat.byte_last) state_d = hht_pkg::S_HFIN;
			hht_pkg::S_HFIN:     state_d = hht_pkg::S_MAP_RD;
			hht_pkg::S_MAP_RD:   state_d = hht_pkg::S_MAP_CAP;
			hht_pkg::S_MAP_CAP:  state_d = hht_pkg::S_FIND;
			hht_pkg::S_FIND: begin
				if (stat.bit_hit) state_d = hht_pkg::S_FIND_CMP;
				else if (stat.i_last) state_d = hht_pkg::S_NOTFOUND;
			end
			hht_pkg::S_FIND_CMP: begin
				if (stat.key_match) state_d = hht_pkg::S_HIT;
				else if (stat.i_last) state_d = hht_pkg::S_NOTFOUND;
				else state_d = hht_pkg::S_FIND;
			end
			hht_pkg::S_HIT:      state_d = hht_pkg::S_EMIT;
			hht_pkg::S_NOTFOUND: begin
				if (stat.op == hht_pkg::OP_INSERT) state_d = hht_pkg::S_PROBE_RD;
				else state_d = hht_pkg::S_EMIT;
			end
			hht_pkg::S_PROBE_RD: state_d = hht_pkg::S_PROBE_CHK;
			hht_pkg::S_PROBE_CHK: begin
				if (!stat.taken) state_d = hht_pkg::S_DISP;
				else if (stat.probe_last) state_d = hht_pkg::S_EMIT;
				else state_d = hht_pkg::S_PROBE_RD;
			end
			hht_pkg::S_DISP: begin
				if (stat.in_hood) state_d = hht_pkg::S_FINAL_WR;
				else state_d = hht_pkg::S_MOVE_RD;
			end
			hht_pkg::S_MOVE_RD:  state_d = hht_pkg::S_MOVE_CHK;
			hht_pkg::S_MOVE_CHK: begin
				if (stat.move_ok) state_d = hht_pkg::S_MOVE_KRD;
				else if (stat.j_last) state_d = hht_pkg::S_EMIT;
				else state_d = hht_pkg::S_MOVE_RD;
			end
			hht_pkg::S_MOVE_KRD: state_d = hht_pkg::S_MOVE_WR;
			hht_pkg::S_MOVE_WR:  state_d = hht_pkg::S_DISP;
			hht_pkg::S_FINAL_WR: state_d = hht_pkg::S_EMIT;
			hht_pkg::S_EMIT:     if (slot_free) state_d = hht_pkg::S_IDLE;
			default:             state_d = hht_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = hht_pkg::DP_NOP;
		cmd.st   = hht_pkg::ST_MISS;
		in_ready = 1'b0;
		case (state_q)
			hht_pkg::S_CLEAR: cmd.op = hht_pkg::DP_CLEAR;
			hht_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = hht_pkg::DP_LOAD;
			end
			hht_pkg::S_HASH:    cmd.op = hht_pkg::DP_HASH;
			hht_pkg::S_HFIN:    cmd.op = hht_pkg::DP_HFIN;
			hht_pkg::S_MAP_RD:  cmd.op = hht_pkg::DP_MAP_RD;
			hht_pkg::S_MAP_CAP: cmd.op = hht_pkg::DP_MAP_CAP;
			hht_pkg::S_FIND: begin
				if (stat.bit_hit) cmd.op = hht_pkg::DP_FIND_RD;
				else if (!stat.i_last) cmd.op = hht_pkg::DP_FIND_NEXT;
			end
			hht_pkg::S_FIND_CMP: begin
				if (!stat.key_match && !stat.i_last) cmd.op = hht_pkg::DP_FIND_NEXT;
			end
			hht_pkg::S_HIT: begin
				case (stat.op)
					hht_pkg::OP_LOOKUP: cmd.op = hht_pkg::DP_LK_HIT;
					hht_pkg::OP_REMOVE: cmd.op = hht_pkg::DP_REMOVE;
					hht_pkg::OP_INSERT: begin
						cmd.op = hht_pkg::DP_SET_RES;
						cmd.st = hht_pkg::ST_DUP;
					end
					default: cmd.op = hht_pkg::DP_SET_RES;
				endcase
			end
			hht_pkg::S_NOTFOUND: begin
				if (stat.op == hht_pkg::OP_INSERT) cmd.op = hht_pkg::DP_PROBE_INIT;
				else cmd.op = hht_pkg::DP_SET_RES;
			end
			hht_pkg::S_PROBE_RD: cmd.op = hht_pkg::DP_PROBE_RD;
			hht_pkg::S_PROBE_CHK: begin
				if (!stat.taken) begin
					cmd.op = hht_pkg::DP_PROBE_TAKE;
				end else if (stat.probe_last) begin
					cmd.op = hht_pkg::DP_SET_RES;
					cmd.st = hht_pkg::ST_FULL;
				end else begin
					cmd.op = hht_pkg::DP_PROBE_NEXT;
				end
			end
			hht_pkg::S_DISP: begin
				if (stat.in_hood) cmd.op = hht_pkg::DP_FINAL_RD;
				else cmd.op = hht_pkg::DP_MOVE_INIT;
			end
			hht_pkg::S_MOVE_RD: cmd.op = hht_pkg::DP_MOVE_RD;
			hht_pkg::S_MOVE_CHK: begin
				if (stat.move_ok) begin
					cmd.op = hht_pkg::DP_MOVE_CAP;
				end else if (stat.j_last) begin
					cmd.op = hht_pkg::DP_HOOD_REL;
					cmd.st = hht_pkg::ST_HOOD;
				end else begin
					cmd.op = hht_pkg::DP_MOVE_NEXT;
				end
			end
			hht_pkg::S_MOVE_KRD: cmd.op = hht_pkg::DP_MOVE_KRD;
			hht_pkg::S_MOVE_WR:  cmd.op = hht_pkg::DP_MOVE_WR;
			hht_pkg::S_FINAL_WR: cmd.op = hht_pkg::DP_FINAL_WR;
			hht_pkg::S_EMIT:     if (slot_free) cmd.op = hht_pkg::DP_EMIT;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hht_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == hht_pkg::DP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_accept_starts_hash: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == hht_pkg::S_HASH)
		else $error("accepted item did not start hashing");

	a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == hht_pkg::DP_EMIT |-> !out_valid_q || out_ready)
		else $error("result overwrote a pending transfer");

	a_emit_raises_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == hht_pkg::DP_EMIT |=> out_valid_q)
		else $error("result not presented after emit");

	a_no_accept_outside_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != hht_pkg::S_IDLE |-> !in_ready)
		else $error("input ready outside idle");

endmodule

### rtl/hopscotch_hash_table_engine.sv
// Each request hashes the key byte by byte, then compares keys at the set home bitmap bits.
// An insert that misses probes for a free bucket and displaces entries toward its home.
// One request is in flight at a time; bucket memories with one read a cycle set the pace.
// A finished result waits in an output register while the next request is taken.
// After reset a clearing pass over all 2**TABLE_LOG2 buckets zeroes bitmaps and taken flags.
module hopscotch_hash_table_engine #(
	parameter int TABLE_LOG2 = hht_pkg::TABLE_LOG2_DEF,
	parameter int HOP_RANGE  = hht_pkg::HOP_RANGE_DEF,
	parameter int KEY_BYTES  = hht_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BITS = hht_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [63:0] key,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [63:0] value_out
);

	hht_pkg::cmd_t  cmd;
	hht_pkg::stat_t stat;

	hht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd)
	);

	hht_datapath #(
		.TABLE_LOG2(TABLE_LOG2), .HOP_RANGE(HOP_RANGE),
		.KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.operation(operation), .key(key), .value(value),
		.status(status), .value_out(value_out)
	);

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the hopscotch hash table engine with a built-in predictor.
`timescale 1ns / 1ps

import hht_pkg::*;

class hopscotch_predictor;
	typedef struct {
		status_t     st;
		logic [63:0] data;
	} response_t;

	logic [63:0] slot_keys[1024];
	logic [63:0] slot_values[1024];
	logic [31:0] hood_maps[1024];
	bit          slot_taken[1024];
	logic [3:0]  size_exp;
	response_t   pending_responses[$];
	int          mismatches;
	int          status_seen[5];

	function new();
		for (int b = 0; b < 1024; b++) begin
			slot_keys[b] = '0;
			slot_values[b] = '0;
			hood_maps[b] = '0;
			slot_taken[b] = 0;
		end
		size_exp = SIZE_EXP_RESET;
		mismatches = 0;
		for (int s = 0; s < 5; s++) begin
			status_seen[s] = 0;
		end
	endfunction

	function logic [31:0] oaat(logic [63:0] k);
		logic [31:0] h;
		h = 0;
		for (int b = 0; b < 8; b++) begin
			h = h + 32'(k[8*b +: 8]);
			h = h + (h << 10);
			h = h ^ (h >> 6);
		end
		h = h + (h << 3);
		h = h ^ (h >> 11);
		h = h + (h << 15);
		return h;
	endfunction

	function int bucket_count();
		int e;
		e = size_exp;
		if (e < 1) e = 1;
		if (e > 10) e = 10;
		return 1 << e;
	endfunction

	function int home_of(logic [63:0] k);
		return int'(oaat(k) & 32'(bucket_count() - 1));
	endfunction

	function int find_offset(int home, logic [63:0] k);
		for (int i = 0; i < 32; i++) begin
			if (hood_maps[home][i] && home + i < 1024 && slot_keys[home + i] == k) begin
				return i;
			end
		end
		return -1;
	endfunction

	function status_t place(int home, int sz, logic [63:0] k, logic [63:0] v);
		int i;
		int j;
		int anchor;
		int off;
		int src;
		logic [31:0] m;
		i = home;
		while (i < sz && slot_taken[i]) i++;
		if (i >= sz) return ST_FULL;
		slot_taken[i] = 1;
		while (i - home >= 32) begin
			for (j = 1; j < 32; j++) begin
				anchor = i - j;
				m = hood_maps[anchor];
				if (m == 0) continue;
				off = 0;
				while (off < 31 && !m[off]) off++;
				if (off >= j) continue;
				src = anchor + off;
				slot_keys[i] = slot_keys[src];
				slot_values[i] = slot_values[src];
				slot_keys[src] = '0;
				slot_values[src] = '0;
				m[off] = 1'b0;
				m[j] = 1'b1;
				hood_maps[anchor] = m;
				i = src;
				break;
			end
			if (j >= 32) begin
				slot_taken[i] = 0;
				return ST_HOOD;
			end
		end
		slot_keys[i] = k;
		slot_values[i] = v;
		hood_maps[home][i - home] = 1'b1;
		return ST_OK;
	endfunction

	function void note_request(op_t op, logic [63:0] k, logic [63:0] v);
		response_t r;
		int home;
		int s;
		home = home_of(k);
		r.st = ST_MISS;
		r.data = '0;
		case (op)
			OP_LOOKUP: begin
				s = find_offset(home, k);
				if (s >= 0) begin
					r.st = ST_OK;
					r.data = slot_values[home + s];
				end
			end
			OP_INSERT: begin
				if (find_offset(home, k) >= 0) r.st = ST_DUP;
				else r.st = place(home, bucket_count(), k, v);
			end
			OP_REMOVE: begin
				s = find_offset(home, k);
				if (s >= 0) begin
					r.data = slot_values[home + s];
					hood_maps[home][s] = 1'b0;
					slot_keys[home + s] = '0;
					slot_values[home + s] = '0;
					slot_taken[home + s] = 0;
					r.st = ST_OK;
				end
			end
			default: ;
		endcase
		pending_responses.push_back(r);
	endfunction

	task report_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	task check_response(logic [2:0] st, logic [63:0] data);
		response_t r;
		if (pending_responses.size() == 0) begin
			report_mismatch($sformatf("unexpected response status %0d", st));
		end else begin
			r = pending_responses.pop_front();
			if (st < 5) status_seen[st]++;
			if (st !== r.st)
				report_mismatch($sformatf("status %0d, want %0d", st, r.st));
			if (data !== r.data)
				report_mismatch($sformatf("value_out %h, want %h", data, r.data));
		end
	endtask
endclass

module tb_top;
	localparam int CYCLE_LIMIT = 20_000_000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [63:0] key;
	logic [63:0] value;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [63:0] value_out;

	hopscotch_predictor pred = new();
	int cycles;
	int results_seen;
	int items_sent;
	int burst_left;
	int hold_left;
	int stall_mode;
	bit held;
	logic [63:0] key_pool[$];

	hopscotch_hash_table_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.key       (key),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.value_out (value_out)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				pred.check_response(status, value_out);
				results_seen++;
			end
			if (cycles % 50 == 0) stall_mode = $urandom_range(0, 2);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!held && results_seen >= 300 && in_valid) begin
				held = 1;
				hold_left = 400;
				out_ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task send_item(op_t op, logic [63:0] k, logic [63:0] v);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		key <= k;
		value <= v;
		do @(posedge clk); while (!in_ready);
		pred.note_request(op, k, v);
		items_sent++;
	endtask

	task set_size(logic [3:0] e);
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pred.pending_responses.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= e;
		@(posedge clk);
		cfg_we <= 1'b0;
		pred.size_exp = e;
	endtask

	function logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task run_mix(logic [3:0] e, int n, int pool_size);
		op_t op;
		int r;
		logic [63:0] k;
		set_size(e);
		key_pool.delete();
		repeat (pool_size) key_pool.push_back(rand64());
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 45) op = OP_INSERT;
			else if (r < 75) op = OP_LOOKUP;
			else if (r < 95) op = OP_REMOVE;
			else op = OP_UNUSED;
			if ($urandom_range(0, 9) == 0) k = rand64();
			else k = key_pool[$urandom_range(0, pool_size - 1)];
			send_item(op, k, rand64());
		end
	endtask

	task run_crowd();
		logic [63:0] k;
		set_size(4'd7);
		key_pool.delete();
		while (key_pool.size() < 34) begin
			k = rand64();
			if (pred.home_of(k) == 0) key_pool.push_back(k);
		end
		foreach (key_pool[i]) send_item(OP_INSERT, key_pool[i], rand64());
		foreach (key_pool[i]) send_item(OP_LOOKUP, key_pool[i], rand64());
		for (int i = 0; i < 34; i += 2) send_item(OP_REMOVE, key_pool[i], rand64());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		operation = '0;
		key = '0;
		value = '0;
		out_ready = 1'b0;
		cycles = 0;
		results_seen = 0;
		items_sent = 0;
		burst_left = 0;
		hold_left = 0;
		stall_mode = 0;
		held = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_size(4'd10);
		send_item(OP_INSERT, '0, '0);
		send_item(OP_INSERT, '1, '1);
		send_item(OP_LOOKUP, '0, '1);
		send_item(OP_LOOKUP, '1, '0);
		send_item(OP_INSERT, '0, 64'h5555_aaaa_5555_aaaa);
		send_item(OP_LOOKUP, 64'h0123_4567_89ab_cdef, '0);
		send_item(OP_REMOVE, '1, '0);
		send_item(OP_REMOVE, '1, '0);
		send_item(OP_LOOKUP, '1, '0);
		send_item(OP_UNUSED, '0, '1);
		send_item(OP_INSERT, 64'haaaa_5555_aaaa_5555, 64'h5555_aaaa_5555_aaaa);
		send_item(OP_LOOKUP, 64'haaaa_5555_aaaa_5555, '0);
		send_item(OP_REMOVE, '0, '1);

		run_mix(4'd1, 80, 6);
		run_mix(4'd15, 150, 200);
		run_mix(4'd0, 60, 5);
		run_mix(4'd6, 250, 90);
		run_crowd();
		run_mix(4'd4, 150, 30);
		run_mix(4'd10, 170, 150);

		in_valid <= 1'b0;
		while (pred.pending_responses.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d requests, %0d responses; ok %0d miss %0d dup %0d full %0d hood %0d",
			items_sent, results_seen, pred.status_seen[0], pred.status_seen[1],
			pred.status_seen[2], pred.status_seen[3], pred.status_seen[4]);
		$display("table sizes 2 to 1024 buckets, with a crowded home bucket and a long output stall");
		if (pred.mismatches == 0 && pred.pending_responses.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
